// ===== rtl/core/s2l_pkg.sv =====
`default_nettype none

package s2l_pkg;

	// one solar date item in packed bcd
	typedef struct packed {
		logic       century_sel;
		logic [7:0] solar_year_bcd;
		logic [4:0] solar_month_bcd;
		logic [5:0] solar_day_bcd;
	} solar_date_t;

	// one lunar date item in packed bcd
	typedef struct packed {
		logic       lunar_century;
		logic [7:0] lunar_year_bcd;
		logic [4:0] lunar_month_bcd;
		logic [5:0] lunar_day_bcd;
		logic       out_of_range;
	} lunar_date_t;

	// datapath operations selected by the control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INDEX,
		OP_FETCH,
		OP_PREP,
		OP_SPLIT,
		OP_BINIT,
		OP_FWALK,
		OP_BWALK,
		OP_EMIT,
		OP_EMIT_FAIL
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ACCEPT,
		C_GE,
		C_WALK_END,
		C_OUT_FREE
	} cond_t;

	typedef logic [3:0] uaddr_t;

	// microcode addresses
	localparam uaddr_t UA_IDLE   = 4'd0;
	localparam uaddr_t UA_INDEX  = 4'd1;
	localparam uaddr_t UA_FETCH  = 4'd2;
	localparam uaddr_t UA_PREP   = 4'd3;
	localparam uaddr_t UA_SPLIT  = 4'd4;
	localparam uaddr_t UA_BFETCH = 4'd5;
	localparam uaddr_t UA_BINIT  = 4'd6;
	localparam uaddr_t UA_BWALK  = 4'd7;
	localparam uaddr_t UA_FWALK  = 4'd8;
	localparam uaddr_t UA_DONE   = 4'd9;
	localparam uaddr_t UA_FAIL   = 4'd10;

	// control word: operation, jump condition, advance-when-not-taken, jump target
	typedef struct packed {
		op_t    op;
		cond_t  cond;
		logic   adv;
		uaddr_t target;
	} uword_t;

	function automatic uword_t ucode(input uaddr_t a);
		uword_t w;
		case (a)
			UA_IDLE:   w = '{op: OP_LOAD,      cond: C_ACCEPT,   adv: 1'b0, target: UA_INDEX};
			UA_INDEX:  w = '{op: OP_INDEX,     cond: C_NEVER,    adv: 1'b1, target: UA_IDLE};
			UA_FETCH:  w = '{op: OP_FETCH,     cond: C_NEVER,    adv: 1'b1, target: UA_IDLE};
			UA_PREP:   w = '{op: OP_PREP,      cond: C_NEVER,    adv: 1'b1, target: UA_IDLE};
			UA_SPLIT:  w = '{op: OP_SPLIT,     cond: C_GE,       adv: 1'b1, target: UA_FWALK};
			UA_BFETCH: w = '{op: OP_FETCH,     cond: C_NEVER,    adv: 1'b1, target: UA_IDLE};
			UA_BINIT:  w = '{op: OP_BINIT,     cond: C_NEVER,    adv: 1'b1, target: UA_IDLE};
			UA_BWALK:  w = '{op: OP_BWALK,     cond: C_WALK_END, adv: 1'b0, target: UA_DONE};
			UA_FWALK:  w = '{op: OP_FWALK,     cond: C_WALK_END, adv: 1'b0, target: UA_DONE};
			UA_DONE:   w = '{op: OP_EMIT,      cond: C_OUT_FREE, adv: 1'b0, target: UA_IDLE};
			UA_FAIL:   w = '{op: OP_EMIT_FAIL, cond: C_OUT_FREE, adv: 1'b0, target: UA_IDLE};
			default:   w = '{op: OP_NOP,       cond: C_NEVER,    adv: 1'b0, target: UA_IDLE};
		endcase
		return w;
	endfunction

	// lunar year table, 1901 to 2099: {leap month, 13 month-length bits, new-year code}
	localparam int ROM_DEPTH = 199;
	localparam logic [23:0] LUNAR_ROM [ROM_DEPTH] = '{
		24'h04ae53, 24'h0a5748, 24'h5526bd, 24'h0d2650, 24'h0d9544,
		24'h46aab9, 24'h056a4d, 24'h09ad42, 24'h24aeb6, 24'h04ae4a,
		24'h6a4dbe, 24'h0a4d52, 24'h0d2546, 24'h5d52ba, 24'h0b544e,
		24'h0d6a43, 24'h296d37, 24'h095b4b, 24'h749bc1, 24'h049754,
		24'h0a4b48, 24'h5b25bc, 24'h06a550, 24'h06d445, 24'h4adab8,
		24'h02b64d, 24'h095742, 24'h2497b7, 24'h04974a, 24'h664b3e,
		24'h0d4a51, 24'h0ea546, 24'h56d4ba, 24'h05ad4e, 24'h02b644,
		24'h393738, 24'h092e4b, 24'h7c96bf, 24'h0c9553, 24'h0d4a48,
		24'h6da53b, 24'h0b554f, 24'h056a45, 24'h4aadb9, 24'h025d4d,
		24'h092d42, 24'h2c95b6, 24'h0a954a, 24'h7b4abd, 24'h06ca51,
		24'h0b5546, 24'h555abb, 24'h04da4e, 24'h0a5b43, 24'h352bb8,
		24'h052b4c, 24'h8a953f, 24'h0e9552, 24'h06aa48, 24'h7ad53c,
		24'h0ab54f, 24'h04b645, 24'h4a5739, 24'h0a574d, 24'h052642,
		24'h3e9335, 24'h0d9549, 24'h75aabe, 24'h056a51, 24'h096d46,
		24'h54aebb, 24'h04ad4f, 24'h0a4d43, 24'h4d26b7, 24'h0d254b,
		24'h8d52bf, 24'h0b5452, 24'h0b6a47, 24'h696d3c, 24'h095b50,
		24'h049b45, 24'h4a4bb9, 24'h0a4b4d, 24'hab25c2, 24'h06a554,
		24'h06d449, 24'h6ada3d, 24'h0ab651, 24'h093746, 24'h5497bb,
		24'h04974f, 24'h064b44, 24'h36a537, 24'h0ea54a, 24'h86b2bf,
		24'h05ac53, 24'h0ab647, 24'h5936bc, 24'h092e50, 24'h0c9645,
		24'h4d4ab8, 24'h0d4a4c, 24'h0da541, 24'h25aab6, 24'h056a49,
		24'h7aadbd, 24'h025d52, 24'h092d47, 24'h5c95ba, 24'h0a954e,
		24'h0b4a43, 24'h4b5537, 24'h0ad54a, 24'h955abf, 24'h04ba53,
		24'h0a5b48, 24'h652bbc, 24'h052b50, 24'h0a9345, 24'h474ab9,
		24'h06aa4c, 24'h0ad541, 24'h24dab6, 24'h04b64a, 24'h69573d,
		24'h0a4e51, 24'h0d2646, 24'h5e933a, 24'h0d534d, 24'h05aa43,
		24'h36b537, 24'h096d4b, 24'hb4aebf, 24'h04ad53, 24'h0a4d48,
		24'h6d25bc, 24'h0d254f, 24'h0d5244, 24'h5daa38, 24'h0b5a4c,
		24'h056d41, 24'h24adb6, 24'h049b4a, 24'h7a4bbe, 24'h0a4b51,
		24'h0aa546, 24'h5b52ba, 24'h06d24e, 24'h0ada42, 24'h355b37,
		24'h09374b, 24'h8497c1, 24'h049753, 24'h064b48, 24'h66a53c,
		24'h0ea54f, 24'h06b244, 24'h4ab638, 24'h0aae4c, 24'h092e42,
		24'h3c9735, 24'h0c9649, 24'h7d4abd, 24'h0d4a51, 24'h0da545,
		24'h55aaba, 24'h056a4e, 24'h0a6d43, 24'h452eb7, 24'h052d4b,
		24'h8a95bf, 24'h0a9553, 24'h0b4a47, 24'h6b553b, 24'h0ad54f,
		24'h055a45, 24'h4a5d38, 24'h0a5b4c, 24'h052b42, 24'h3a93b6,
		24'h069349, 24'h7729bd, 24'h06aa51, 24'h0ad546, 24'h54daba,
		24'h04b64e, 24'h0a5743, 24'h452738, 24'h0d264a, 24'h8e933e,
		24'h0d5252, 24'h0daa47, 24'h66b53b, 24'h056d4f, 24'h04ae45,
		24'h4a4eb9, 24'h0a4d4c, 24'h0d1541, 24'h2d92b5
	};

	// days before solar month m in a common year
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'h000;
			4'd2:    r = 9'h01f;
			4'd3:    r = 9'h03b;
			4'd4:    r = 9'h05a;
			4'd5:    r = 9'h078;
			4'd6:    r = 9'h097;
			4'd7:    r = 9'h0b5;
			4'd8:    r = 9'h0d4;
			4'd9:    r = 9'h0f3;
			4'd10:   r = 9'h111;
			4'd11:   r = 9'h130;
			4'd12:   r = 9'h14e;
			default: r = 9'h000;
		endcase
		return r;
	endfunction

	// binary 0..99 to packed bcd, tens by reciprocal multiply
	function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 14'(v) * 14'd103;
		tens = prod[13:10];
		ones = v - 7'(7'({3'b000, tens}) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/solar_to_lunar_date_converter_top.sv =====
`default_nettype none

// solar to chinese lunar date converter, 1901 to 2099. a request item carries a packed
// bcd solar date (century flag, year, month, day); one response item comes back per
// request with the packed bcd lunar date, where a leap month carries the number of the
// month it follows. malformed bcd, a month or day out of range, year 1900, a date before
// lunar new year 1901 or a walk past either end of a lunar year raise out_of_range
// with all other fields zero. the work is run by a small microcode program: a step
// counter reads one control word per cycle from a fixed table, and the word drives the
// date datapath and picks the next step. a request is loaded, indexed, fetched, prepared
// and split; a date before lunar new year then fetches the previous year and sets up a
// backward walk. the walk steps through the lunar months one at a time (up to 13), and a
// final step hands the result to the output register. a bad encoding is flagged at the
// index step and a date before lunar new year 1901 at the split step. the lunar year
// table is read one year at a time through a registered read. a new request is taken
// while the previous response still waits in the output register; the program only
// stalls at its final step while that register is full and held by rsp_stall.
module solar_to_lunar_date_converter_top
	import s2l_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire solar_date_t req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output lunar_date_t      rsp
);

	// sequencer
	uaddr_t upc_q;
	uaddr_t upc_next;
	uword_t uw;
	logic   taken;
	logic   fail_hit;

	// datapath registers
	logic        cs_q;
	logic [6:0]  y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic        err_q;
	logic [7:0]  yi_q;
	logic [23:0] rom_q;
	logic [5:0]  off_q;
	logic [8:0]  doy_q;
	logic [8:0]  acc_q;
	logic [3:0]  p_q;
	logic [3:0]  leap_q;
	logic [4:0]  lday_q;
	logic        rsp_valid_q;
	lunar_date_t rsp_q;

	// request decode
	logic [3:0] y_ten;
	logic [3:0] y_one;
	logic [7:0] y_bin;
	logic [4:0] m_bin;
	logic [1:0] d_ten;
	logic [3:0] d_one;
	logic [5:0] d_bin;
	logic       ld_err;

	// walk helpers
	logic [4:0] len_c;
	logic [3:0] nm_c;
	logic       ge_c;
	logic       fwd_more;
	logic       bwd_more;
	logic       walk_more;
	logic       out_free;
	logic [3:0] lmon_c;
	logic [7:0] lmon_bcd;
	logic [7:0] lday_bcd;
	logic [7:0] year_bcd;

	assign uw = ucode(upc_q);

	// bcd to binary, tens times ten as shift and add
	always_comb begin
		y_ten = req.solar_year_bcd[7:4];
		y_one = req.solar_year_bcd[3:0];
		y_bin = 8'({y_ten, 3'b000}) + 8'({y_ten, 1'b0}) + 8'(y_one);
		m_bin = req.solar_month_bcd[4] ? (5'd10 + 5'(req.solar_month_bcd[3:0]))
			: 5'(req.solar_month_bcd[3:0]);
		d_ten = req.solar_day_bcd[5:4];
		d_one = req.solar_day_bcd[3:0];
		d_bin = 6'({d_ten, 3'b000}) + 6'({d_ten, 1'b0}) + 6'(d_one);
		ld_err = (y_ten > 4'd9) || (y_one > 4'd9) || (req.solar_month_bcd[3:0] > 4'd9)
			|| (d_one > 4'd9) || (m_bin == 5'd0) || (m_bin > 5'd12)
			|| (d_bin == 6'd0) || (d_bin > 6'd31)
			|| (req.century_sel && (y_bin == 8'd0));
	end

	// month slot p sits at bit 20-p of the table word; 1 means 30 days
	always_comb begin
		len_c     = rom_q[5'd20 - {1'b0, p_q}] ? 5'd30 : 5'd29;
		nm_c      = (leap_q != 4'd0) ? 4'd13 : 4'd12;
		ge_c      = doy_q >= {3'b000, off_q};
		fwd_more  = acc_q >= {4'b0000, len_c};
		bwd_more  = acc_q > {4'b0000, len_c};
		walk_more = (uw.op == OP_FWALK) ? fwd_more : bwd_more;
		out_free  = !rsp_valid_q || !rsp_stall;
		lmon_c    = ((leap_q != 4'd0) && (p_q > leap_q)) ? (p_q - 4'd1) : p_q;
		lmon_bcd  = bin_to_bcd({3'b000, lmon_c});
		lday_bcd  = bin_to_bcd({2'b00, lday_q});
		year_bcd  = bin_to_bcd(y_q);
	end

	// failures that divert the program to the flagged response
	always_comb begin
		case (uw.op)
			OP_INDEX: fail_hit = err_q;
			OP_SPLIT: fail_hit = !ge_c && (yi_q == 8'd0);
			OP_FWALK: fail_hit = fwd_more && (p_q >= nm_c);
			OP_BWALK: fail_hit = bwd_more && (p_q == 4'd1);
			default:  fail_hit = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		case (uw.cond)
			C_NEVER:    taken = 1'b0;
			C_ACCEPT:   taken = req_valid;
			C_GE:       taken = ge_c;
			C_WALK_END: taken = !walk_more;
			C_OUT_FREE: taken = out_free;
			default:    taken = 1'b0;
		endcase
		if (fail_hit) begin
			upc_next = UA_FAIL;
		end else if (taken) begin
			upc_next = uw.target;
		end else if (uw.adv) begin
			upc_next = upc_q + 4'd1;
		end else begin
			upc_next = upc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	// response register, written by the last step of the program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (((uw.op == OP_EMIT) || (uw.op == OP_EMIT_FAIL)) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((uw.op == OP_EMIT) && out_free) begin
			rsp_q.lunar_century   <= cs_q;
			rsp_q.lunar_year_bcd  <= year_bcd;
			rsp_q.lunar_month_bcd <= lmon_bcd[4:0];
			rsp_q.lunar_day_bcd   <= lday_bcd[5:0];
			rsp_q.out_of_range    <= 1'b0;
		end else if ((uw.op == OP_EMIT_FAIL) && out_free) begin
			rsp_q.lunar_century   <= 1'b0;
			rsp_q.lunar_year_bcd  <= 8'd0;
			rsp_q.lunar_month_bcd <= 5'd0;
			rsp_q.lunar_day_bcd   <= 6'd0;
			rsp_q.out_of_range    <= 1'b1;
		end
	end

	// datapath, one operation per control word
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (req_valid) begin
					cs_q  <= req.century_sel;
					y_q   <= y_bin[6:0];
					m_q   <= m_bin[3:0];
					d_q   <= d_bin[4:0];
					err_q <= ld_err;
				end
			end
			OP_INDEX: begin
				yi_q <= cs_q ? (8'(y_q) - 8'd1) : (8'(y_q) + 8'd99);
			end
			OP_FETCH: begin
				rom_q <= LUNAR_ROM[yi_q];
			end
			OP_PREP: begin
				// new year in january or february; a table day of zero never occurs
				off_q <= (rom_q[6:5] == 2'b01) ? (6'(rom_q[4:0]) - 6'd1)
					: (6'(rom_q[4:0]) + 6'd30);
				doy_q <= month_start(m_q) + 9'(d_q) - 9'd1
					+ 9'((m_q > 4'd2) && (y_q[1:0] == 2'b00));
			end
			OP_SPLIT: begin
				if (ge_c) begin
					acc_q  <= doy_q - {3'b000, off_q};
					p_q    <= 4'd1;
					leap_q <= rom_q[23:20];
				end else begin
					// count back from the end of the previous lunar year
					acc_q <= {3'b000, off_q} - doy_q;
					yi_q  <= yi_q - 8'd1;
					if (!cs_q && (y_q == 7'd0)) begin
						y_q  <= 7'd99;
						cs_q <= 1'b1;
					end else begin
						y_q <= y_q - 7'd1;
					end
				end
			end
			OP_BINIT: begin
				leap_q <= rom_q[23:20];
				p_q    <= (rom_q[23:20] != 4'd0) ? 4'd13 : 4'd12;
			end
			OP_FWALK: begin
				if (fwd_more) begin
					acc_q <= acc_q - {4'b0000, len_c};
					p_q   <= p_q + 4'd1;
				end else begin
					lday_q <= acc_q[4:0] + 5'd1;
				end
			end
			OP_BWALK: begin
				if (bwd_more) begin
					acc_q <= acc_q - {4'b0000, len_c};
					p_q   <= p_q - 4'd1;
				end else begin
					lday_q <= len_c - acc_q[4:0] + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (upc_q != UA_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a failure check always lands in the flagged response step
	a_fail_goes_fail: assert property (@(posedge clk) disable iff (!arst_n)
		fail_hit |=> (upc_q == UA_FAIL))
		else $error("failure did not reach the flagged step");

	// month slot stays within one lunar year while walking
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		((upc_q == UA_FWALK) || (upc_q == UA_BWALK)) |-> ((p_q >= 4'd1) && (p_q <= 4'd13)))
		else $error("month slot out of range during walk");

	// lunar day at the result step is 1..30
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UA_DONE) |-> ((lday_q >= 5'd1) && (lday_q <= 5'd30)))
		else $error("lunar day out of range");

	// a response only appears out of the two final steps
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(upc_q) == UA_DONE || $past(upc_q) == UA_FAIL))
		else $error("response raised outside the final steps");

endmodule

`default_nettype wire
